// ----- sv/stepper_phase_sequencer_unit_assert.svh -----
// Assertion macros for the port-level checker of the stepper phase sequencer.
`ifndef STEPPER_PHASE_SEQUENCER_UNIT_ASSERT_SVH
`define STEPPER_PHASE_SEQUENCER_UNIT_ASSERT_SVH

// Same-cycle implication, held off while reset is asserted.
`define SPS_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define SPS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/sps_pkg.sv -----
// Types and constants shared by the stepper phase sequencer modules.
package sps_pkg;

    localparam int PINS_W     = 8;
    localparam int POS_W      = 32;
    localparam int STEPS_W    = 31;
    localparam int PERIOD_W   = 16;
    localparam int HZ_W       = 20;
    localparam int HOLD_W     = 16;
    localparam int CNT_W      = 4;
    localparam int TABLE_W    = 64;
    localparam int MODE_W     = 2;
    localparam int CFG_AW     = 6;
    localparam int CFG_DW     = 64;
    localparam int REG_IDX_W  = 3;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 96;

    localparam logic [REG_IDX_W-1:0] REG_LIMIT_LOW   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_LIMIT_HIGH  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_PHASE_COUNT = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PHASE_TABLE = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_HOLD_TICKS  = 3'd4;

    localparam logic [HZ_W-1:0]     DIV_DIVIDEND = 20'd1000000;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX   = 16'hFFFF;
    localparam logic [PERIOD_W-1:0] PERIOD_MIN   = 16'd2;
    localparam logic [HOLD_W-1:0]   HOLD_RESET   = 16'd100;
    localparam logic [CNT_W-1:0]    COUNT_RESET  = 4'd4;
    localparam logic [STEPS_W-1:0]  STEPS_SAT    = 31'h7FFF_FFFF;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK,
        MODE_MOVE,
        MODE_RATE,
        MODE_ESTOP
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_TICK,
        ST_ESTOP,
        ST_MV_ABS,
        ST_MV_TGT,
        ST_MV_HI,
        ST_MV_LO,
        ST_MV_FIN,
        ST_RATE_GO,
        ST_RATE_WAIT,
        ST_RATE_SET,
        ST_RESULT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_TICK,
        OP_ESTOP,
        OP_MV_ABS,
        OP_MV_TGT,
        OP_MV_HI,
        OP_MV_LO,
        OP_MV_FIN,
        OP_DIV_START,
        OP_RATE_SET
    } op_t;

    typedef struct packed {
        logic load_in;
        op_t  op;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  estop;
        logic  div_done;
    } sts_t;

    typedef struct packed {
        logic [3:0]             pad;
        logic [HZ_W-1:0]        rate_hz;
        logic signed [POS_W-1:0] step_count;
    } in_data_t;

    typedef struct packed {
        logic [3:0]              pad;
        logic                    stopped;
        logic                    locked;
        logic                    moving;
        logic [STEPS_W-1:0]      steps_left;
        logic signed [POS_W-1:0] position;
        logic [PERIOD_W-1:0]     pulse_period;
        logic                    drive_enable;
        logic                    dir_pin;
        logic [PINS_W-1:0]       phase_pins;
    } out_item_t;

    typedef struct packed {
        logic                 we;
        logic [REG_IDX_W-1:0] idx;
        logic [CFG_DW-1:0]    data;
    } cfg_wr_t;

    typedef struct packed {
        logic signed [POS_W-1:0] limit_low;
        logic signed [POS_W-1:0] limit_high;
        logic [CNT_W-1:0]        phase_count;
        logic [TABLE_W-1:0]      phase_table;
        logic [HOLD_W-1:0]       hold_ticks;
    } cfg_t;

endpackage

// ----- sv/sps_div.sv -----
// Restoring divider: constant dividend by the rate, one quotient bit per cycle.
module sps_div (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [sps_pkg::HZ_W-1:0] divisor,
    output logic [sps_pkg::HZ_W-1:0] quotient,
    output logic                     done
);
    import sps_pkg::*;

    localparam int                 CNT_BITS = $clog2(HZ_W);
    localparam logic [CNT_BITS-1:0] LAST    = CNT_BITS'(HZ_W - 1);

    logic [HZ_W-1:0]     rem_reg, rem_next;
    logic [HZ_W-1:0]     quo_reg, quo_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [HZ_W:0]       shifted;
    logic [HZ_W+1:0]     diff;

    // A zero divisor never borrows, so the quotient comes out all ones.
    assign shifted = {rem_reg, quo_reg[HZ_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, divisor};

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = DIV_DIVIDEND;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[HZ_W+1]) begin
                rem_next = diff[HZ_W-1:0];
                quo_next = {quo_reg[HZ_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[HZ_W-1:0];
                quo_next = {quo_reg[HZ_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ----- sv/sps_ctrl.sv -----
// Controller state machine: sequences one transaction through the datapath.
module sps_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic          m_tready,
    output logic          m_tvalid,
    output sps_pkg::cmd_t cmd,
    input  sps_pkg::sts_t sts
);
    import sps_pkg::*;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (s_tvalid) state_next = ST_DECODE;
            ST_DECODE: begin
                if (sts.mode == MODE_ESTOP) begin
                    state_next = ST_ESTOP;
                end else if (sts.estop) begin
                    state_next = ST_RESULT;
                end else begin
                    case (sts.mode)
                        MODE_TICK: state_next = ST_TICK;
                        MODE_MOVE: state_next = ST_MV_ABS;
                        MODE_RATE: state_next = ST_RATE_GO;
                        default:   state_next = ST_RESULT;
                    endcase
                end
            end
            ST_TICK:      state_next = ST_RESULT;
            ST_ESTOP:     state_next = ST_RESULT;
            ST_MV_ABS:    state_next = ST_MV_TGT;
            ST_MV_TGT:    state_next = ST_MV_HI;
            ST_MV_HI:     state_next = ST_MV_LO;
            ST_MV_LO:     state_next = ST_MV_FIN;
            ST_MV_FIN:    state_next = ST_RESULT;
            ST_RATE_GO:   state_next = ST_RATE_WAIT;
            ST_RATE_WAIT: if (sts.div_done) state_next = ST_RATE_SET;
            ST_RATE_SET:  state_next = ST_RESULT;
            ST_RESULT:    if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd          = '{load_in: 1'b0, op: OP_NONE, load_out: 1'b0};
        s_tready     = 1'b0;
        m_valid_next = m_tready ? 1'b0 : m_valid_reg;
        case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            ST_TICK:     cmd.op = OP_TICK;
            ST_ESTOP:    cmd.op = OP_ESTOP;
            ST_MV_ABS:   cmd.op = OP_MV_ABS;
            ST_MV_TGT:   cmd.op = OP_MV_TGT;
            ST_MV_HI:    cmd.op = OP_MV_HI;
            ST_MV_LO:    cmd.op = OP_MV_LO;
            ST_MV_FIN:   cmd.op = OP_MV_FIN;
            ST_RATE_GO:  cmd.op = OP_DIV_START;
            ST_RATE_SET: cmd.op = OP_RATE_SET;
            ST_RESULT: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;

endmodule

// ----- sv/sps_datapath.sv -----
// Datapath: configuration registers, motion state, rate divider and result register.
module sps_datapath #(
    parameter int MAX_PHASES  = 8,
    parameter int PHASE_WIDTH = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  sps_pkg::cmd_t      cmd,
    output sps_pkg::sts_t      sts,
    input  sps_pkg::mode_t     in_mode,
    input  sps_pkg::in_data_t  in_data,
    input  sps_pkg::cfg_wr_t   cfg_wr,
    output sps_pkg::cfg_t      cfg,
    output sps_pkg::out_item_t out_item
);
    import sps_pkg::*;

    localparam int                IDX_W      = $clog2(MAX_PHASES);
    localparam logic [CNT_W-1:0]  PHASES_MAX = CNT_W'(MAX_PHASES);
    localparam logic [PINS_W-1:0] PAT_MASK   = PINS_W'((1 << PHASE_WIDTH) - 1);

    function automatic logic [PINS_W-1:0] pattern(input logic [TABLE_W-1:0] tbl,
                                                  input logic [IDX_W-1:0]   idx);
        logic [TABLE_W-1:0] sh;
        sh = tbl >> {idx, 3'b000};
        return sh[PINS_W-1:0] & PAT_MASK;
    endfunction

    function automatic logic [CNT_W-1:0] count_used(input logic [CNT_W-1:0] c);
        return (c > PHASES_MAX) ? PHASES_MAX : c;
    endfunction

    function automatic logic [STEPS_W-1:0] sat_steps(input logic signed [POS_W+1:0] v);
        if (v[POS_W+1])
            return '0;
        else if (v[POS_W:STEPS_W] != 2'b00)
            return STEPS_SAT;
        else
            return v[STEPS_W-1:0];
    endfunction

    cfg_t                    cfg_reg, cfg_next;
    mode_t                   mode_reg;
    logic signed [POS_W-1:0] step_reg;
    logic [HZ_W-1:0]         hz_reg;
    logic signed [POS_W-1:0] pos_reg, pos_next;
    logic [STEPS_W-1:0]      rem_reg, rem_next;
    logic                    dir_reg, dir_next;
    logic                    dirpin_reg, dirpin_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [HOLD_W-1:0]       idle_reg, idle_next;
    logic                    lock_reg, lock_next;
    logic                    moving_reg, moving_next;
    logic                    estop_reg, estop_next;
    logic                    en_reg, en_next;
    logic [PINS_W-1:0]       pins_reg, pins_next;
    logic [PERIOD_W-1:0]     period_reg, period_next;
    logic signed [POS_W:0]   tgt_reg, tgt_next;
    out_item_t               out_reg;

    logic [CNT_W-1:0]        n_used;
    logic [IDX_W-1:0]        cur_idx;
    logic [CNT_W-1:0]        inc_idx;
    logic [IDX_W-1:0]        fwd_idx, bwd_idx;
    logic [HOLD_W-1:0]       idle_inc;
    logic signed [POS_W:0]   step_ext, step_mag;
    logic [HZ_W-1:0]         quotient;
    logic                    div_done;

    sps_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.op == OP_DIV_START),
        .divisor  (hz_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    // Phase walk: restart from entry zero when the index lies beyond the count.
    assign n_used   = count_used(cfg_reg.phase_count);
    assign cur_idx  = (CNT_W'(idx_reg) >= n_used) ? '0 : idx_reg;
    assign inc_idx  = CNT_W'(cur_idx) + 1'b1;
    assign fwd_idx  = (inc_idx >= n_used) ? '0 : IDX_W'(inc_idx);
    assign bwd_idx  = (cur_idx == '0) ? IDX_W'(n_used - 1'b1) : cur_idx - 1'b1;
    assign idle_inc = (idle_reg == '1) ? idle_reg : idle_reg + 1'b1;
    assign step_ext = (POS_W+1)'(step_reg);
    assign step_mag = step_reg[POS_W-1] ? -step_ext : step_ext;

    always_comb begin
        cfg_next    = cfg_reg;
        pos_next    = pos_reg;
        rem_next    = rem_reg;
        dir_next    = dir_reg;
        dirpin_next = dirpin_reg;
        idx_next    = idx_reg;
        idle_next   = idle_reg;
        lock_next   = lock_reg;
        moving_next = moving_reg;
        estop_next  = estop_reg;
        en_next     = en_reg;
        pins_next   = pins_reg;
        period_next = period_reg;
        tgt_next    = tgt_reg;

        case (cmd.op)
            OP_TICK: begin
                if (rem_reg == '0) begin
                    if (!lock_reg) begin
                        idle_next = idle_inc;
                        if (idle_inc >= cfg_reg.hold_ticks) begin
                            lock_next = 1'b1;
                            en_next   = 1'b0;
                            pins_next = '0;
                        end
                    end
                end else begin
                    if (lock_reg) begin
                        lock_next = 1'b0;
                        idle_next = '0;
                        en_next   = 1'b1;
                    end
                    dirpin_next = dir_reg;
                    if (n_used != '0) begin
                        pins_next = pattern(cfg_reg.phase_table, cur_idx);
                        idx_next  = dir_reg ? fwd_idx : bwd_idx;
                        rem_next  = rem_reg - 1'b1;
                        pos_next  = dir_reg ? pos_reg + 32'sd1 : pos_reg - 32'sd1;
                        if (rem_reg == STEPS_W'(1)) moving_next = 1'b0;
                    end
                end
            end
            OP_ESTOP: begin
                en_next     = 1'b0;
                pins_next   = '0;
                moving_next = 1'b0;
                estop_next  = 1'b1;
                lock_next   = 1'b0;
                idle_next   = '0;
                rem_next    = '0;
            end
            OP_MV_ABS: begin
                dir_next = !step_reg[POS_W-1];
                rem_next = sat_steps((POS_W+2)'(step_mag));
            end
            OP_MV_TGT: tgt_next = (POS_W+1)'(pos_reg) + step_ext;
            OP_MV_HI: begin
                if (cfg_reg.limit_high > 0 && tgt_reg > (POS_W+1)'(cfg_reg.limit_high))
                    rem_next = sat_steps((POS_W+2)'(cfg_reg.limit_high)
                                         - (POS_W+2)'(pos_reg));
            end
            OP_MV_LO: begin
                if (cfg_reg.limit_low < 0 && tgt_reg < (POS_W+1)'(cfg_reg.limit_low))
                    rem_next = sat_steps((POS_W+2)'(pos_reg)
                                         - (POS_W+2)'(cfg_reg.limit_low));
            end
            OP_MV_FIN: begin
                dirpin_next = dir_reg;
                moving_next = (rem_reg != '0);
                lock_next   = 1'b0;
                idle_next   = '0;
                if (rem_reg != '0) en_next = 1'b1;
            end
            OP_RATE_SET: begin
                if (quotient > HZ_W'(PERIOD_MAX))
                    period_next = PERIOD_MAX;
                else if (quotient < HZ_W'(PERIOD_MIN))
                    period_next = PERIOD_MIN;
                else
                    period_next = quotient[PERIOD_W-1:0];
            end
            default: ;
        endcase

        // The user writes registers only with no transaction in flight; unenforced.
        if (cfg_wr.we) begin
            case (cfg_wr.idx)
                REG_LIMIT_LOW:   cfg_next.limit_low  = cfg_wr.data[POS_W-1:0];
                REG_LIMIT_HIGH:  cfg_next.limit_high = cfg_wr.data[POS_W-1:0];
                REG_PHASE_COUNT: begin
                    cfg_next.phase_count = cfg_wr.data[CNT_W-1:0];
                    if (count_used(cfg_wr.data[CNT_W-1:0]) != '0) begin
                        idx_next  = '0;
                        pins_next = pattern(cfg_reg.phase_table, '0);
                    end
                end
                REG_PHASE_TABLE: begin
                    cfg_next.phase_table = cfg_wr.data;
                    if (n_used != '0) begin
                        idx_next  = '0;
                        pins_next = pattern(cfg_wr.data, '0);
                    end
                end
                REG_HOLD_TICKS:  cfg_next.hold_ticks = cfg_wr.data[HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.limit_low   <= '0;
            cfg_reg.limit_high  <= '0;
            cfg_reg.phase_count <= COUNT_RESET;
            cfg_reg.phase_table <= '0;
            cfg_reg.hold_ticks  <= HOLD_RESET;
            pos_reg             <= '0;
            rem_reg             <= '0;
            dir_reg             <= 1'b1;
            dirpin_reg          <= 1'b1;
            idx_reg             <= '0;
            idle_reg            <= '0;
            lock_reg            <= 1'b0;
            moving_reg          <= 1'b0;
            estop_reg           <= 1'b0;
            en_reg              <= 1'b0;
            pins_reg            <= '0;
            period_reg          <= PERIOD_MAX;
        end else begin
            cfg_reg    <= cfg_next;
            pos_reg    <= pos_next;
            rem_reg    <= rem_next;
            dir_reg    <= dir_next;
            dirpin_reg <= dirpin_next;
            idx_reg    <= idx_next;
            idle_reg   <= idle_next;
            lock_reg   <= lock_next;
            moving_reg <= moving_next;
            estop_reg  <= estop_next;
            en_reg     <= en_next;
            pins_reg   <= pins_next;
            period_reg <= period_next;
        end
    end

    always_ff @(posedge aclk) begin
        tgt_reg <= tgt_next;
        if (cmd.load_in) begin
            mode_reg <= in_mode;
            step_reg <= in_data.step_count;
            hz_reg   <= in_data.rate_hz;
        end
        if (cmd.load_out) begin
            out_reg.pad          <= '0;
            out_reg.stopped      <= estop_reg;
            out_reg.locked       <= lock_reg;
            out_reg.moving       <= moving_reg;
            out_reg.steps_left   <= rem_reg;
            out_reg.position     <= pos_reg;
            out_reg.pulse_period <= period_reg;
            out_reg.drive_enable <= en_reg;
            out_reg.dir_pin      <= dirpin_reg;
            out_reg.phase_pins   <= pins_reg;
        end
    end

    assign sts      = '{mode: mode_reg, estop: estop_reg, div_done: div_done};
    assign cfg      = cfg_reg;
    assign out_item = out_reg;

endmodule

// ----- sv/stepper_phase_sequencer_unit.sv -----
// Top level of the stepper phase sequencer: stream ports, register port, controller, datapath.
//
//  Channel   | Ports                          | Carries
//  ----------+--------------------------------+----------------------------------------------
//  command   | s_tvalid s_tready s_tdata      | one tick, move, rate or stop per transaction
//            | s_tuser                        |   (mode in s_tuser)
//  status    | m_tvalid m_tready m_tdata      | one status word per command, state after it
//  registers | psel penable pwrite paddr      | limits, phase count, phase table, hold ticks
//            | pwdata prdata pready           |   (64-bit, register i at byte 8*i)
//
// One command is handled at a time; the controller steps it through the datapath.
// From accept to next accept: a tick or stop runs decode, its operation and result; a command
// ignored after a stop runs decode and result; a move runs abs, target, high, low and finish
// (one 33/34-bit add and compare each); a rate waits on the restoring divider's 20 one-bit steps.
// The status word sits in an output register, so the next command is taken while it waits;
// a stalled m_tready holds only the final write-back.
// Reset is synchronous and active low; all motion state and registers return to defaults.
module stepper_phase_sequencer_unit #(
    parameter int MAX_PHASES  = 8,
    parameter int PHASE_WIDTH = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // command channel
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [sps_pkg::IN_DATA_W-1:0]   s_tdata,  // step_count[31:0], rate_hz[51:32], zero pad
    input  logic [sps_pkg::MODE_W-1:0]      s_tuser,  // mode[1:0]
    // status channel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sps_pkg::OUT_DATA_W-1:0]  m_tdata,  // phase_pins[7:0], dir_pin[8],
                                                      // drive_enable[9], pulse_period[25:10],
                                                      // position[57:26], steps_left[88:58],
                                                      // moving[89], locked[90], stopped[91],
                                                      // zero pad
    // register port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sps_pkg::CFG_AW-1:0]      paddr,
    input  logic [sps_pkg::CFG_DW-1:0]      pwdata,
    output logic [sps_pkg::CFG_DW-1:0]      prdata,
    output logic                            pready
);
    import sps_pkg::*;

    cmd_t      cmd;
    sts_t      sts;
    cfg_wr_t   cfg_wr;
    cfg_t      cfg;
    out_item_t out_item;
    logic [REG_IDX_W-1:0] reg_idx;

    // Decode the register index from the 8-byte aligned address.
    assign reg_idx = paddr[CFG_AW-1:3];
    assign pready  = 1'b1;

    assign cfg_wr = '{we:   psel && penable && pwrite && pready,
                      idx:  reg_idx,
                      data: pwdata};

    // Read back straight from the registers; limits sign-extend.
    always_comb begin
        case (reg_idx)
            REG_LIMIT_LOW:   prdata = CFG_DW'(cfg.limit_low);
            REG_LIMIT_HIGH:  prdata = CFG_DW'(cfg.limit_high);
            REG_PHASE_COUNT: prdata = CFG_DW'(cfg.phase_count);
            REG_PHASE_TABLE: prdata = cfg.phase_table;
            REG_HOLD_TICKS:  prdata = CFG_DW'(cfg.hold_ticks);
            default:         prdata = '0;
        endcase
    end

    sps_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .cmd      (cmd),
        .sts      (sts)
    );

    sps_datapath #(
        .MAX_PHASES  (MAX_PHASES),
        .PHASE_WIDTH (PHASE_WIDTH)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .in_mode  (mode_t'(s_tuser)),
        .in_data  (in_data_t'(s_tdata)),
        .cfg_wr   (cfg_wr),
        .cfg      (cfg),
        .out_item (out_item)
    );

    assign m_tdata = out_item;

endmodule

// ----- sv/sps_checker.sv -----
// Port-level checker for the stepper phase sequencer, bound to the top level.
`include "stepper_phase_sequencer_unit_assert.svh"

module sps_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata
);

    // A latched stop never clears before reset.
    `SPS_ASSERT_NEXT(a_stop_sticky, aclk, aresetn, m_tvalid && m_tdata[91], !m_tvalid || m_tdata[91], "stopped flag cleared without reset")

    // A stopped drive shows no enable, no motion and no steps left.
    `SPS_ASSERT_IMPL(a_stop_quiet, aclk, aresetn, m_tvalid && m_tdata[91], !m_tdata[9] && !m_tdata[89] && (m_tdata[88:58] == 31'd0), "motion reported after stop")

    // A locked drive has its enable off.
    `SPS_ASSERT_IMPL(a_lock_off, aclk, aresetn, m_tvalid && m_tdata[90], !m_tdata[9], "drive enabled while locked")

    // The moving flag tracks whether steps remain.
    `SPS_ASSERT_IMPL(a_moving_steps, aclk, aresetn, m_tvalid, m_tdata[89] == (m_tdata[88:58] != 31'd0), "moving flag disagrees with steps left")

    // A stalled status word holds.
    `SPS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "status word changed while stalled")

endmodule

bind stepper_phase_sequencer_unit sps_checker u_sps_checker (.*);

// ----- bench/stepper_status_checker.sv -----
// Status checker for the stepper phase sequencer: mirrors the motion state, compares each status word.
module stepper_status_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [sps_pkg::IN_DATA_W-1:0]  s_tdata,   // step_count[31:0], rate_hz[51:32], zero pad
    input  logic [sps_pkg::MODE_W-1:0]     s_tuser,   // mode[1:0]
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [sps_pkg::OUT_DATA_W-1:0] m_tdata,   // phase_pins[7:0], dir_pin[8],
                                                      // drive_enable[9], pulse_period[25:10],
                                                      // position[57:26], steps_left[88:58],
                                                      // moving[89], locked[90], stopped[91]
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sps_pkg::CFG_AW-1:0]     paddr,
    input  logic [sps_pkg::CFG_DW-1:0]     pwdata,
    input  logic                           pready,
    output int                             fail_count,
    output int                             pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import sps_pkg::*;

    localparam int MAX_PHASES = 8;

    // register copies
    logic signed [POS_W-1:0] lim_lo;
    logic signed [POS_W-1:0] lim_hi;
    logic [CNT_W-1:0]        ph_count;
    logic [TABLE_W-1:0]      ph_table;
    logic [HOLD_W-1:0]       hold_limit;

    // motion state
    logic signed [POS_W-1:0] pos;
    logic [STEPS_W-1:0]      steps_to_go;
    logic                    fwd;
    logic                    dir_out;
    int unsigned             ph_idx;
    logic [HOLD_W-1:0]       idle_ticks;
    logic                    locked_f;
    logic                    moving_f;
    logic                    stopped_f;
    logic                    enabled_f;
    logic [PINS_W-1:0]       pins;
    logic [PERIOD_W-1:0]     period;

    out_item_t expected_status[$];
    int        status_seen = 0;

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    function automatic int unsigned phases_in_use();
        return (ph_count > CNT_W'(MAX_PHASES)) ? MAX_PHASES : int'(ph_count);
    endfunction

    function automatic logic [PINS_W-1:0] table_entry(int unsigned idx);
        return ph_table[(idx % 8) * 8 +: 8];
    endfunction

    function automatic logic [STEPS_W-1:0] clip_steps(longint v);
        if (v < 0) return '0;
        if (v > 64'sd2147483647) return STEPS_SAT;
        return STEPS_W'(v);
    endfunction

    task automatic reset_model();
        lim_lo      = '0;
        lim_hi      = '0;
        ph_count    = COUNT_RESET;
        ph_table    = '0;
        hold_limit  = HOLD_RESET;
        pos         = '0;
        steps_to_go = '0;
        fwd         = 1'b1;
        dir_out     = 1'b1;
        ph_idx      = 0;
        idle_ticks  = '0;
        locked_f    = 1'b0;
        moving_f    = 1'b0;
        stopped_f   = 1'b0;
        enabled_f   = 1'b0;
        pins        = '0;
        period      = PERIOD_MAX;
    endtask

    // A new table or count restarts the sequence at entry 0, unless stepping is disabled.
    task automatic restart_phases();
        if (phases_in_use() != 0) begin
            ph_idx = 0;
            pins   = table_entry(0);
        end
    endtask

    task automatic write_register(logic [REG_IDX_W-1:0] idx, logic [CFG_DW-1:0] v);
        case (idx)
            REG_LIMIT_LOW:   lim_lo = v[POS_W-1:0];
            REG_LIMIT_HIGH:  lim_hi = v[POS_W-1:0];
            REG_PHASE_COUNT: begin
                ph_count = v[CNT_W-1:0];
                restart_phases();
            end
            REG_PHASE_TABLE: begin
                ph_table = v;
                restart_phases();
            end
            REG_HOLD_TICKS:  hold_limit = v[HOLD_W-1:0];
            default: ;
        endcase
    endtask

    task automatic do_move(logic signed [POS_W-1:0] req);
        longint s;
        longint p;
        longint target;
        s      = req;
        p      = pos;
        target = p + s;
        fwd         = (s >= 0);
        steps_to_go = clip_steps(s >= 0 ? s : -s);
        if (lim_hi > 0 && target > longint'(lim_hi)) steps_to_go = clip_steps(longint'(lim_hi) - p);
        if (lim_lo < 0 && target < longint'(lim_lo)) steps_to_go = clip_steps(p - longint'(lim_lo));
        dir_out    = fwd;
        moving_f   = (steps_to_go != 0);
        locked_f   = 1'b0;
        if (moving_f) enabled_f = 1'b1;
        idle_ticks = '0;
    endtask

    task automatic do_tick();
        int unsigned n;
        if (steps_to_go == 0) begin
            if (!locked_f) begin
                if (idle_ticks != 16'hFFFF) idle_ticks++;
                if (idle_ticks >= hold_limit) begin
                    locked_f  = 1'b1;
                    enabled_f = 1'b0;
                    pins      = '0;
                end
            end
        end else begin
            if (locked_f) begin
                locked_f   = 1'b0;
                idle_ticks = '0;
                enabled_f  = 1'b1;
            end
            dir_out = fwd;
            n = phases_in_use();
            if (n != 0) begin
                if (ph_idx >= n) ph_idx = 0;
                pins = table_entry(ph_idx);
                if (fwd) ph_idx = (ph_idx + 1 >= n) ? 0 : ph_idx + 1;
                else     ph_idx = (ph_idx == 0) ? n - 1 : ph_idx - 1;
                steps_to_go--;
                pos = fwd ? pos + 1 : pos - 1;
                if (steps_to_go == 0) moving_f = 1'b0;
            end
        end
    endtask

    task automatic do_rate(logic [HZ_W-1:0] hz);
        int unsigned q;
        if (hz == 0) begin
            period = PERIOD_MAX;
        end else begin
            q = int'(DIV_DIVIDEND) / int'(hz);
            if (q < int'(PERIOD_MIN))      period = PERIOD_MIN;
            else if (q > int'(PERIOD_MAX)) period = PERIOD_MAX;
            else                           period = PERIOD_W'(q);
        end
    endtask

    task automatic take_command(mode_t mode, logic signed [POS_W-1:0] steps, logic [HZ_W-1:0] hz);
        out_item_t st;
        if (mode == MODE_ESTOP) begin
            enabled_f   = 1'b0;
            pins        = '0;
            moving_f    = 1'b0;
            stopped_f   = 1'b1;
            locked_f    = 1'b0;
            idle_ticks  = '0;
            steps_to_go = '0;
        end else if (!stopped_f) begin
            case (mode)
                MODE_TICK: do_tick();
                MODE_MOVE: do_move(steps);
                default:   do_rate(hz);
            endcase
        end
        st              = '0;
        st.phase_pins   = pins;
        st.dir_pin      = dir_out;
        st.drive_enable = enabled_f;
        st.pulse_period = period;
        st.position     = pos;
        st.steps_left   = steps_to_go;
        st.moving       = moving_f;
        st.locked       = locked_f;
        st.stopped      = stopped_f;
        expected_status.push_back(st);
    endtask

    task automatic check_field(string name, longint unsigned want_v, longint unsigned got_v);
        if (want_v != got_v) begin
            if (fail_count < 10)
                $display("status %0d field %s: expected %0h, got %0h",
                         status_seen, name, want_v, got_v);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin : monitor
        out_item_t got;
        out_item_t want;
        in_data_t  cmd;
        if (!aresetn) begin
            reset_model();
            expected_status.delete();
        end else begin
            if (psel && penable && pwrite && pready)
                write_register(paddr[CFG_AW-1:3], pwdata);
            // status word leaves before the command taken at the same edge can produce one
            if (m_tvalid && m_tready) begin
                got = out_item_t'(m_tdata);
                if (expected_status.size() == 0) begin
                    if (fail_count < 10)
                        $display("status %0d arrived with nothing outstanding: %h",
                                 status_seen, m_tdata);
                    fail_count++;
                end else begin
                    want = expected_status.pop_front();
                    check_field("phase_pins",   want.phase_pins,   got.phase_pins);
                    check_field("dir_pin",      want.dir_pin,      got.dir_pin);
                    check_field("drive_enable", want.drive_enable, got.drive_enable);
                    check_field("pulse_period", want.pulse_period, got.pulse_period);
                    check_field("position",     32'(want.position), 32'(got.position));
                    check_field("steps_left",   want.steps_left,   got.steps_left);
                    check_field("moving",       want.moving,       got.moving);
                    check_field("locked",       want.locked,       got.locked);
                    check_field("stopped",      want.stopped,      got.stopped);
                end
                status_seen++;
            end
            if (s_tvalid && s_tready) begin
                cmd = in_data_t'(s_tdata);
                take_command(mode_t'(s_tuser), cmd.step_count, cmd.rate_hz);
            end
        end
        pending = expected_status.size();
    end

endmodule

// ----- bench/testbench.sv -----
// Testbench top for the stepper phase sequencer: clock, reset, commands, register writes, verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import sps_pkg::*;

    // Generous ceiling on the run, far above the slowest legal run.
    localparam int RUN_LIMIT = 500000;
    // Length of the deliberate status back-pressure stretch.
    localparam int LONG_HOLD = 300;
    // Commands per random phase.
    localparam int PHASE_ITEMS = 170;

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;   // step_count[31:0], rate_hz[51:32], zero pad
    logic [MODE_W-1:0]     s_tuser = '0;   // mode[1:0]
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;        // phase_pins[7:0] .. stopped[91], see checker
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [CFG_AW-1:0]     paddr   = '0;
    logic [CFG_DW-1:0]     pwdata  = '0;
    logic [CFG_DW-1:0]     prdata;
    logic                  pready;

    int fail_count;
    int pending;
    int cycle_count   = 0;
    int commands_sent = 0;

    // Sender and receiver share these: back_to_back drops all idling, hold_request asks the
    // receiver for one long back-pressure stretch (it clears the flag itself when done).
    logic back_to_back = 1'b0;
    logic hold_request = 1'b0;

    always #6ns aclk = ~aclk;

    stepper_phase_sequencer_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    stepper_status_checker status_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Watchdog: abandon the run once the cycle counter reaches RUN_LIMIT.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("stepper_phase_sequencer_unit verification failed");
            $finish;
        end
    end

    // Status receiver: drop m_tready for a random number of cycles before each transaction,
    // and hold it low for the long stretch whenever the sender asks for one.
    initial begin : status_sink
        int stall;
        @(negedge aclk);
        forever begin
            if (hold_request) begin
                m_tready = 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                hold_request = 1'b0;
            end
            stall = back_to_back ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    // One register write: setup cycle, then access cycle until pready. Enter and leave on a
    // falling edge so back-to-back writes chain without a gap.
    task automatic reg_write(logic [REG_IDX_W-1:0] idx, logic [CFG_DW-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 3'b000};
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Offer one command transaction after a random gap. tvalid stays high on return so a
    // zero gap gives a back-to-back transaction; the next call lowers it if it idles.
    task automatic send_command(mode_t mode, logic signed [POS_W-1:0] steps,
                                logic [HZ_W-1:0] hz);
        int gap;
        gap = back_to_back ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tuser  = mode;
        s_tdata  = {4'b0000, hz, steps};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        commands_sent++;
        @(negedge aclk);
    endtask

    // Stop offering and hold until every status word owed has been collected.
    task automatic drain();
        s_tvalid = 1'b0;
        wait (pending == 0);
        @(negedge aclk);
    endtask

    function automatic logic signed [POS_W-1:0] random_steps();
        int                      sel;
        logic signed [POS_W-1:0] mag;
        sel = $urandom_range(0, 99);
        if (sel < 70)      mag = $urandom_range(0, 40);
        else if (sel < 85) mag = $urandom_range(0, 4000);
        else if (sel < 95) return $urandom;
        else return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    function automatic logic [HZ_W-1:0] pick_rate();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 2) return $urandom_range(0, 20);
        if (sel < 6) return $urandom_range(10, 5000);
        return $urandom_range(0, 20'hFFFFF);
    endfunction

    // Mostly well-formed motion: a short move followed by enough ticks to finish it and then
    // idle on towards the hold timeout, with the odd rate change mixed in. The rest is noise.
    // Unused fields always carry random bits.
    task automatic random_sequence();
        int kind;
        int n;
        kind = $urandom_range(0, 9);
        if (kind < 6) begin
            n = $urandom_range(0, 12);
            send_command(MODE_MOVE, $urandom_range(0, 1) ? -n : n, $urandom);
            n = n + $urandom_range(0, 10);
            repeat (n) begin
                if ($urandom_range(0, 15) == 0) send_command(MODE_RATE, $urandom, pick_rate());
                else                            send_command(MODE_TICK, $urandom, $urandom);
            end
        end else if (kind < 8) begin
            send_command(MODE_MOVE, random_steps(), $urandom);
        end else if (kind < 9) begin
            send_command(MODE_RATE, $urandom, pick_rate());
        end else begin
            repeat ($urandom_range(1, 6)) send_command(MODE_TICK, $urandom, $urandom);
        end
    endtask

    // Register settings per phase: the first four pin down the extremes (tight limits,
    // full-range limits, limits that never engage with stepping disabled and an instant
    // hold timeout, an oversized phase count), the rest are random.
    task automatic configure_phase(int ph);
        logic signed [POS_W-1:0] lo;
        logic signed [POS_W-1:0] hi;
        logic [CNT_W-1:0]        cnt;
        logic [HOLD_W-1:0]       hold;
        case (ph)
            0: begin lo = -30;           hi = 30;            cnt = 4'd4;  hold = 16'd3;     end
            1: begin lo = 32'sh8000_0000; hi = 32'sh7FFF_FFFF; cnt = 4'd8; hold = 16'hFFFF; end
            2: begin lo = 25;            hi = -25;           cnt = 4'd0;  hold = 16'd0;     end
            3: begin lo = -8;            hi = 8;             cnt = 4'd15; hold = 16'd1;     end
            default: begin
                lo   = -$urandom_range(0, 60);
                hi   = $urandom_range(0, 60);
                cnt  = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
                hold = $urandom_range(0, 12);
            end
        endcase
        reg_write(REG_LIMIT_LOW,   {32'h0, lo});
        reg_write(REG_LIMIT_HIGH,  {32'h0, hi});
        reg_write(REG_PHASE_TABLE, {$urandom, $urandom});
        reg_write(REG_PHASE_COUNT, {60'h0, cnt});
        reg_write(REG_HOLD_TICKS,  {48'h0, hold});
    endtask

    initial begin : stimulus
        int target;

        // Hold reset low, then release it on a falling edge.
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed: a distinct pattern per entry so the pin sequence shows the index order.
        reg_write(REG_LIMIT_LOW,   {32'h0, -32'sd1000});
        reg_write(REG_LIMIT_HIGH,  {32'h0, 32'sd1000});
        reg_write(REG_PHASE_TABLE, 64'h8040_2010_0906_0A05);
        reg_write(REG_PHASE_COUNT, 64'd4);
        reg_write(REG_HOLD_TICKS,  64'd4);

        // idle ticks up to the hold timeout and one more while locked
        repeat (5) send_command(MODE_TICK, '0, '0);
        // short moves both ways, run to completion; then a zero-length move
        send_command(MODE_MOVE, 3, '0);
        repeat (3) send_command(MODE_TICK, '0, '0);
        send_command(MODE_MOVE, -2, 20'hFFFFF);
        repeat (2) send_command(MODE_TICK, 32'hFFFF_FFFF, '0);
        send_command(MODE_MOVE, 0, '0);
        // rate: zero, the upper clamp, just inside both ends and the lower clamp
        send_command(MODE_RATE, '0, 20'd0);
        send_command(MODE_RATE, '0, 20'd1);
        send_command(MODE_RATE, '0, 20'd16);
        send_command(MODE_RATE, '0, 20'd500000);
        send_command(MODE_RATE, 32'hFFFF_FFFF, 20'hFFFFF);
        // largest moves either way, clipped at the soft limits
        send_command(MODE_MOVE, 32'sh7FFF_FFFF, '0);
        send_command(MODE_TICK, '0, '0);
        send_command(MODE_MOVE, 32'sh8000_0000, '0);
        send_command(MODE_TICK, '0, '0);
        send_command(MODE_MOVE, 0, '0);
        // disabled stepping: a move stalls under ticks
        drain();
        reg_write(REG_PHASE_COUNT, 64'd0);
        send_command(MODE_MOVE, 2, '0);
        repeat (2) send_command(MODE_TICK, '0, '0);

        // Random phases, each under a fresh register setting written while idle.
        for (int ph = 0; ph < 8; ph++) begin
            drain();
            configure_phase(ph);
            back_to_back = (ph == 5);
            if (ph == 4) hold_request = 1'b1;   // keep offering while status is held off
            target = commands_sent + PHASE_ITEMS;
            while (commands_sent < target) begin
                // now and then pause for all status, then swap the phase table or count
                if ($urandom_range(0, 39) == 0) begin
                    drain();
                    if ($urandom_range(0, 1)) reg_write(REG_PHASE_TABLE, {$urandom, $urandom});
                    else reg_write(REG_PHASE_COUNT, {60'h0, 4'($urandom_range(0, 15))});
                end
                random_sequence();
            end
        end
        back_to_back = 1'b0;

        // Emergency stop in mid-move; everything after it is ignored except register writes.
        drain();
        reg_write(REG_PHASE_COUNT, 64'd4);
        send_command(MODE_MOVE, 20, '0);
        repeat (3) send_command(MODE_TICK, '0, '0);
        send_command(MODE_ESTOP, $urandom, $urandom);
        repeat (4) begin
            send_command(MODE_TICK, $urandom, $urandom);
            send_command(MODE_MOVE, random_steps(), $urandom);
            send_command(MODE_RATE, $urandom, pick_rate());
        end
        drain();
        reg_write(REG_PHASE_TABLE, {$urandom, $urandom});
        reg_write(REG_PHASE_COUNT, 64'd0);
        reg_write(REG_PHASE_COUNT, 64'd5);
        send_command(MODE_TICK, '0, '0);
        send_command(MODE_ESTOP, $urandom, $urandom);
        send_command(MODE_MOVE, 5, '0);

        // Collect the last status words, let the pipeline settle, then give the verdict.
        drain();
        repeat (40) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("stepper_phase_sequencer_unit verification clean");
        else
            $display("stepper_phase_sequencer_unit verification failed");
        $finish;
    end

endmodule
